FILE: hdl/alpha_premultiply_unpremultiply_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the alpha premultiply core
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ALPHA_PREMULTIPLY_UNPREMULTIPLY_CORE_ASSERT_SVH
`define ALPHA_PREMULTIPLY_UNPREMULTIPLY_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define APU_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define APU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/apu_pkg.sv
// ----------------------------------------------------------------------------
// apu_pkg
// Types, constants and helpers shared by the alpha premultiply core.
// ----------------------------------------------------------------------------
`default_nettype none

package apu_pkg;

    // Deepest supported sample, also the number of quotient bits
    localparam int MAX_DEPTH = 16;
    localparam int QUO_BITS  = MAX_DEPTH;
    localparam int MIN_DEPTH = 8;

    // Config bus
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Alpha plane is never processed
    localparam logic [1:0] ALPHA_PLANE = 2'd3;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_INVERSE     = 3'd0,
        REG_DEPTH       = 3'd1,
        REG_ENABLE      = 3'd2,
        REG_FIRST_MODE  = 3'd3,
        REG_OTHER_MODE  = 3'd4
    } reg_idx_t;

    // Plane arithmetic
    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_CENTRED = 2'd1,
        MODE_OFFSET  = 2'd2
    } mode_t;

    typedef struct packed {
        logic       inverse;
        logic [4:0] depth;
        logic [3:0] enable;
        logic [1:0] first_mode;
        logic [1:0] other_mode;
    } cfg_t;

    // Values derived from the sample depth
    typedef struct packed {
        logic [4:0]  d;
        logic [15:0] maxv;
        logic [15:0] half;
        logic [15:0] offs;
    } dparam_t;

    // Item travelling along the divider chain
    typedef struct packed {
        logic [15:0] r;     // final result when no division is used
        logic        div;   // result comes from the quotient
        mode_t       md;
        logic        neg;   // centred colour below half
        logic        ovf;   // quotient at least 2^16
        logic [15:0] rem;
        logic [15:0] quo;   // dividend low bits, quotient shifts in
        logic [15:0] den;
    } stage_t;

    function automatic dparam_t depth_params(input logic [4:0] depth);
        dparam_t    p;
        logic [4:0] d;
        if (depth < 5'(MIN_DEPTH))
            d = 5'(MIN_DEPTH);
        else if (depth > 5'(MAX_DEPTH))
            d = 5'(MAX_DEPTH);
        else
            d = depth;
        p.d    = d;
        p.maxv = 16'((17'd1 << d) - 17'd1);
        p.half = 16'(17'd1 << (d - 5'd1));
        p.offs = 16'(17'd16 << (d - 5'(MIN_DEPTH)));
        return p;
    endfunction

    // Mode code 3 behaves as plain
    function automatic mode_t norm_mode(input logic [1:0] raw);
        mode_t m;
        unique case (raw)
            MODE_CENTRED: m = MODE_CENTRED;
            MODE_OFFSET:  m = MODE_OFFSET;
            default:      m = MODE_PLAIN;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/apu_stream_if.sv
// ----------------------------------------------------------------------------
// apu_in_if / apu_out_if
// Valid/ready sample channels of the alpha premultiply core.
// ----------------------------------------------------------------------------
`default_nettype none

interface apu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  plane_number;
    logic [15:0] colour_sample;
    logic [15:0] alpha_sample;

    modport source (output valid, plane_number, colour_sample, alpha_sample, input ready);
    modport sink   (input valid, plane_number, colour_sample, alpha_sample, output ready);
endinterface

interface apu_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_sample;

    modport source (output valid, result_sample, input ready);
    modport sink   (input valid, result_sample, output ready);
endinterface

`default_nettype wire

FILE: hdl/apu_prep.sv
// ----------------------------------------------------------------------------
// apu_prep
// Two front stages: operand setup and multiply, then premultiply finish or
// divider setup for unpremultiply.
// ----------------------------------------------------------------------------
`default_nettype none

module apu_prep
    import apu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        valid_up,
    output      logic        ready_up,
    input  wire logic [1:0]  plane,
    input  wire logic [15:0] colour,
    input  wire logic [15:0] alpha,
    output      logic        valid_dn,
    input  wire logic        ready_dn,
    output      stage_t      stg_dn
);

    typedef struct packed {
        logic [15:0]        m;
        logic [15:0]        a;
        mode_t              md;
        logic               act;
        logic               neg;
        logic signed [35:0] prod;
    } prep_t;

    function automatic logic [15:0] mode_base(input mode_t md, input dparam_t p);
        logic [15:0] b;
        unique case (md)
            MODE_CENTRED: b = p.half;
            MODE_OFFSET:  b = p.offs;
            default:      b = 16'd0;
        endcase
        return b;
    endfunction

    dparam_t            dp;
    logic               ready_p2;
    logic               v1_reg, v1_next;
    logic               v2_reg, v2_next;
    prep_t              p1_reg, p1_next;
    stage_t             st_reg, st_next;

    logic [15:0]        mm, am;
    logic [16:0]        aa;
    logic [15:0]        base1, base2, rnd;
    logic signed [17:0] x, xmag, mul_a, mul_b;
    logic signed [35:0] sum, shifted;

    assign dp = depth_params(cfg.depth);

    // Handshake through both stages
    assign ready_p2 = !v2_reg || ready_dn;
    assign ready_up = !v1_reg || ready_p2;
    assign v1_next  = ready_up ? valid_up : v1_reg;
    assign v2_next  = ready_p2 ? v1_reg : v2_reg;

    // Stage 1: mask, offset removal, one multiply
    always_comb
    begin
        mm                = colour & dp.maxv;
        am                = alpha & dp.maxv;
        p1_next.m         = mm;
        p1_next.a         = am;
        p1_next.md        = norm_mode((plane == 2'd0) ? cfg.first_mode : cfg.other_mode);
        p1_next.act       = (plane != ALPHA_PLANE) && cfg.enable[plane];
        base1             = mode_base(p1_next.md, dp);
        aa                = {1'b0, am} + {16'd0, am[1]};
        x                 = $signed({2'b00, mm}) - $signed({2'b00, base1});
        xmag              = x[17] ? -x : x;
        p1_next.neg       = x[17] && (p1_next.md == MODE_CENTRED);
        // offset mode clamps negative colour to zero before dividing
        if (x[17] && (p1_next.md == MODE_OFFSET))
            xmag = '0;
        mul_a             = cfg.inverse ? xmag : x;
        mul_b             = cfg.inverse ? $signed({2'b00, dp.maxv}) : $signed({1'b0, aa});
        p1_next.prod      = mul_a * mul_b;
    end

    // Stage 2: premultiply result, or dividend split for the divider chain
    always_comb
    begin
        base2      = mode_base(p1_reg.md, dp);
        rnd        = (p1_reg.md == MODE_CENTRED) ? 16'd0 : dp.half;
        sum        = p1_reg.prod + $signed({20'd0, rnd});
        shifted    = sum >>> dp.d;
        st_next.r   = p1_reg.m;
        st_next.div = 1'b0;
        st_next.md  = p1_reg.md;
        st_next.neg = 1'b0;
        st_next.ovf = 1'b0;
        st_next.rem = p1_reg.prod[31:16];
        st_next.quo = p1_reg.prod[15:0];
        st_next.den = p1_reg.a;
        if (p1_reg.act && !cfg.inverse)
        begin
            st_next.r = shifted[15:0] + base2;
        end
        else if (p1_reg.act && (p1_reg.a != 16'd0) && (p1_reg.a != dp.maxv))
        begin
            st_next.div = 1'b1;
            st_next.neg = p1_reg.neg;
            st_next.ovf = p1_reg.prod[31:16] >= p1_reg.a;
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (ready_up && valid_up)
            p1_reg <= p1_next;
        if (ready_p2 && v1_reg)
            st_reg <= st_next;
    end

    assign valid_dn = v2_reg;
    assign stg_dn   = st_reg;

endmodule

`default_nettype wire

FILE: hdl/apu_div_cell.sv
// ----------------------------------------------------------------------------
// apu_div_cell
// One restoring-division cell: produces one quotient bit per item and
// hands the item to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
`include "alpha_premultiply_unpremultiply_core_assert.svh"

module apu_div_cell
    import apu_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   valid_up,
    output      logic   ready_up,
    input  wire stage_t stg_up,
    output      logic   valid_dn,
    input  wire logic   ready_dn,
    output      stage_t stg_dn
);

    logic        valid_reg, valid_next;
    stage_t      st_reg, st_next;
    logic [16:0] rs, diff;
    logic        ge;

    assign ready_up   = !valid_reg || ready_dn;
    assign valid_next = ready_up ? valid_up : valid_reg;

    // Shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        rs          = {stg_up.rem, stg_up.quo[15]};
        ge          = rs >= {1'b0, stg_up.den};
        diff        = rs - {1'b0, stg_up.den};
        st_next     = stg_up;
        st_next.rem = ge ? diff[15:0] : rs[15:0];
        st_next.quo = {stg_up.quo[14:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_up)
            st_reg <= st_next;
    end

    assign valid_dn = valid_reg;
    assign stg_dn   = st_reg;

    // Remainder stays below the divisor while the quotient fits 16 bits
    `APU_ASSERT_NOW(a_rem_below_den, valid_reg && st_reg.div && !st_reg.ovf, st_reg.rem < st_reg.den, "divider remainder not below divisor")
    // Never divide by zero
    `APU_ASSERT_NOW(a_den_nonzero, valid_reg && st_reg.div, st_reg.den != 16'd0, "division by zero alpha")

endmodule

`default_nettype wire

FILE: hdl/apu_finish.sv
// ----------------------------------------------------------------------------
// apu_finish
// Clamps the quotient per plane mode, or passes on a result that needs no
// division, and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module apu_finish
    import apu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        valid_up,
    output      logic        ready_up,
    input  wire stage_t      stg_up,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [15:0] result
);

    dparam_t     dp;
    logic        valid_reg, valid_next;
    logic [15:0] result_reg, result_next;
    logic [15:0] q;
    logic [16:0] qs;

    assign dp         = depth_params(cfg.depth);
    assign ready_up   = !valid_reg || out_ready;
    assign valid_next = ready_up ? valid_up : valid_reg;

    // Clamp quotient into range
    always_comb
    begin
        q  = stg_up.quo;
        qs = {1'b0, q} + {1'b0, dp.offs};
        result_next = stg_up.r;
        if (stg_up.div)
        begin
            unique case (stg_up.md)
                MODE_CENTRED:
                begin
                    if (stg_up.neg)
                        result_next = (stg_up.ovf || q >= dp.half) ? 16'd0 : dp.half - q;
                    else
                        result_next = (stg_up.ovf || q >= dp.half) ? dp.maxv : q + dp.half;
                end
                MODE_OFFSET:
                    result_next = (stg_up.ovf || qs > {1'b0, dp.maxv}) ? dp.maxv : qs[15:0];
                default:
                    result_next = (stg_up.ovf || q > dp.maxv) ? dp.maxv : q;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_up)
            result_reg <= result_next;
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

FILE: hdl/alpha_premultiply_unpremultiply_core.sv
// ----------------------------------------------------------------------------
// alpha_premultiply_unpremultiply_core
// Per-sample alpha premultiply / unpremultiply with APB configuration.
//
// Items enter on sample_in (plane number, colour, alpha) and leave on
// result_out (one result sample per item), both valid/ready channels.
// The path runs through 19 register stages: two front stages (operand
// setup with one multiply, then premultiply finish or divider setup), a
// row of 16 restoring-division cells giving one quotient bit each, and
// the clamping output register. Every item, premultiply or pass-through,
// walks the same chain, so order is preserved.
// Throughput is one item per cycle while result_out.ready is high; each
// stage moves on when the next one is empty or moving, so a bubble
// anywhere lets a new item in even while the output holds a result that
// has not been taken. When result_out.ready stays low the chain fills up
// and sample_in.ready drops after all stages hold items; nothing is dropped.
// Reset (rst_n low, asynchronous) empties the chain and loads the register
// defaults: premultiply, 8-bit samples, all planes enabled, plane 0 plain,
// planes 1 and 2 centred. Registers should be written through the APB port
// only while no item is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
`include "alpha_premultiply_unpremultiply_core_assert.svh"

module alpha_premultiply_unpremultiply_core
    import apu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    apu_in_if.sink                 sample_in,
    apu_out_if.source              result_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output      logic [DATA_W-1:0] prdata,
    output      logic              pready
);

    cfg_t        cfg_reg;
    logic        cfg_we;
    reg_idx_t    cfg_idx;

    stage_t      stg [0:QUO_BITS];
    logic        vld [0:QUO_BITS];
    logic        rdy [0:QUO_BITS];

    // Config register file
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inverse    <= 1'b0;
            cfg_reg.depth      <= 5'(MIN_DEPTH);
            cfg_reg.enable     <= 4'hf;
            cfg_reg.first_mode <= MODE_PLAIN;
            cfg_reg.other_mode <= MODE_CENTRED;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_INVERSE:    cfg_reg.inverse    <= pwdata[0];
                REG_DEPTH:      cfg_reg.depth      <= pwdata[4:0];
                REG_ENABLE:     cfg_reg.enable     <= pwdata[3:0];
                REG_FIRST_MODE: cfg_reg.first_mode <= pwdata[1:0];
                REG_OTHER_MODE: cfg_reg.other_mode <= pwdata[1:0];
                default:        ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (cfg_idx)
            REG_INVERSE:    prdata = DATA_W'(cfg_reg.inverse);
            REG_DEPTH:      prdata = DATA_W'(cfg_reg.depth);
            REG_ENABLE:     prdata = DATA_W'(cfg_reg.enable);
            REG_FIRST_MODE: prdata = DATA_W'(cfg_reg.first_mode);
            REG_OTHER_MODE: prdata = DATA_W'(cfg_reg.other_mode);
            default:        prdata = '0;
        endcase
    end

    // Front stages
    apu_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .valid_up (sample_in.valid),
        .ready_up (sample_in.ready),
        .plane    (sample_in.plane_number),
        .colour   (sample_in.colour_sample),
        .alpha    (sample_in.alpha_sample),
        .valid_dn (vld[0]),
        .ready_dn (rdy[0]),
        .stg_dn   (stg[0])
    );

    // Divider chain, one quotient bit per cell
    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_cell
        apu_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .valid_up (vld[k]),
            .ready_up (rdy[k]),
            .stg_up   (stg[k]),
            .valid_dn (vld[k+1]),
            .ready_dn (rdy[k+1]),
            .stg_dn   (stg[k+1])
        );
    end

    // Clamp and output register
    apu_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .valid_up  (vld[QUO_BITS]),
        .ready_up  (rdy[QUO_BITS]),
        .stg_up    (stg[QUO_BITS]),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .result    (result_out.result_sample)
    );

    // Input only stalls when every stage is full and the output is blocked
    `APU_ASSERT_NOW(a_stall_only_when_full, !sample_in.ready,
        result_out.valid && !result_out.ready && vld[QUO_BITS] && vld[0],
        "input stalled with room in the chain")

endmodule

`default_nettype wire
